### hw/rtl/bbrt_pkg.sv
// ----------------------------------------------------------------------------
// bbrt_pkg
// Types and constants shared by the bad block remap table.
// ----------------------------------------------------------------------------
package bbrt_pkg;

  localparam int BLK_W  = 31;
  localparam int SLOT_W = 8;
  localparam int CFG_W  = 9;

  typedef logic [BLK_W-1:0] blk_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_XLATE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] entry_index;
    blk_t              bad_block;
    blk_t              spare_block;
    blk_t              block_number;
    blk_t              last_block;
    logic              raw_access;
  } req_t;

  typedef struct packed {
    blk_t physical_block;
    logic was_remapped;
    logic range_has_bad;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

### hw/rtl/bbrt_ram.sv
// ----------------------------------------------------------------------------
// bbrt_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module bbrt_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int W     = 31
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/bbrt_scan.sv
// ----------------------------------------------------------------------------
// bbrt_scan
// Command sequencer: table loads, and the entry scan for translate requests.
// ----------------------------------------------------------------------------
module bbrt_scan #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  bbrt_pkg::req_t            req,
  input  logic [bbrt_pkg::CFG_W-1:0] entry_count,
  output logic                      wr_en,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
  output logic                      rd_en,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  input  bbrt_pkg::blk_t            rd_bad,
  input  bbrt_pkg::blk_t            rd_spare,
  output bbrt_pkg::rsp_t            result,
  output logic                      result_valid
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (DW > bbrt_pkg::CFG_W) ? DW : bbrt_pkg::CFG_W;

  bbrt_pkg::state_t state, state_next;

  bbrt_pkg::blk_t first_q, last_q, phys, phys_n;
  logic [CW-1:0]  n_q, addr, n_start, cnt_ext;
  logic           pend, done1, done2, remap, has_bad;
  logic           done1_n, done2_n, remap_n, has_bad_n;
  logic           accept, issue, slot_ok;

  assign accept  = start && (state == bbrt_pkg::ST_IDLE);
  assign slot_ok = 32'(req.entry_index) < 32'(TABLE_DEPTH);
  assign cnt_ext = CW'(entry_count);
  assign n_start = (cnt_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_ext;

  // evaluate the entry read in the previous cycle
  always_comb begin
    done1_n   = done1;
    done2_n   = done2;
    remap_n   = remap;
    has_bad_n = has_bad;
    phys_n    = phys;
    if (pend) begin
      if (!done1) begin
        if (rd_bad > first_q) begin
          done1_n = 1'b1;
        end else if (rd_bad == first_q) begin
          done1_n = 1'b1;
          remap_n = 1'b1;
          phys_n  = rd_spare;
        end
      end
      if (!done2) begin
        if (last_q < rd_bad) begin
          done2_n = 1'b1;
        end else if (rd_bad >= first_q) begin
          done2_n   = 1'b1;
          has_bad_n = 1'b1;
        end
      end
    end
  end

  assign issue = (state == bbrt_pkg::ST_SCAN) && !(done1_n && done2_n) && (addr < n_q);

  always_comb begin
    state_next = state;
    unique case (state)
      bbrt_pkg::ST_IDLE: begin
        if (accept && req.kind == bbrt_pkg::KIND_XLATE && !req.raw_access) begin
          state_next = bbrt_pkg::ST_SCAN;
        end
      end
      bbrt_pkg::ST_SCAN: begin
        if (!issue) begin
          state_next = bbrt_pkg::ST_IDLE;
        end
      end
      default: state_next = bbrt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state == bbrt_pkg::ST_SCAN);
    rd_en   = issue;
    rd_addr = addr[IW-1:0];
    wr_en   = accept && (req.kind == bbrt_pkg::KIND_LOAD) && slot_ok;
    wr_addr = IW'(req.entry_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bbrt_pkg::ST_IDLE;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pend         <= issue;
      result_valid <= 1'b0;
      if (accept) begin
        result_valid <= (req.kind == bbrt_pkg::KIND_LOAD) || req.raw_access;
      end else if (state == bbrt_pkg::ST_SCAN && !issue) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_q <= req.block_number;
      last_q  <= req.last_block;
      n_q     <= n_start;
      addr    <= '0;
      done1   <= 1'b0;
      done2   <= 1'b0;
      remap   <= 1'b0;
      has_bad <= 1'b0;
      phys    <= req.block_number;
      if (req.kind == bbrt_pkg::KIND_LOAD) begin
        result <= '0;
      end else begin
        result <= '{physical_block: req.block_number, was_remapped: 1'b0,
                    range_has_bad: 1'b0};
      end
    end else if (state == bbrt_pkg::ST_SCAN) begin
      done1   <= done1_n;
      done2   <= done2_n;
      remap   <= remap_n;
      has_bad <= has_bad_n;
      phys    <= phys_n;
      if (issue) begin
        addr <= addr + CW'(1);
      end else begin
        result <= '{physical_block: phys_n, was_remapped: remap_n,
                    range_has_bad: has_bad_n};
      end
    end
  end

endmodule

### hw/rtl/bad_block_remap_table.sv
// ----------------------------------------------------------------------------
// bad_block_remap_table
// Bad block to spare block remap table with range bad check, one per drive.
// ----------------------------------------------------------------------------
// Load and raw-access items: result strobe in the cycle after the transfer.
// Translate items: entries are read one per cycle from the table RAM, so the
// strobe comes after up to min(entry_count, TABLE_DEPTH) entries are read, or
// earlier when the scan can stop. busy stays high until the strobe, so the
// next transfer can follow at the strobe's edge; the receiver cannot stall.
// Synchronous reset clears entry_count and control; table contents are kept.
// ----------------------------------------------------------------------------
module bad_block_remap_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  bbrt_pkg::req_t             req,
  output bbrt_pkg::rsp_t             result,
  output logic                       result_valid,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bbrt_pkg::CFG_W-1:0] cfg_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [bbrt_pkg::CFG_W-1:0] entry_count;
  logic                       wr_en, rd_en;
  logic [IW-1:0]              wr_addr, rd_addr;
  bbrt_pkg::blk_t             rd_bad, rd_spare;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  bbrt_scan #(.TABLE_DEPTH(TABLE_DEPTH)) u_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .entry_count  (entry_count),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_bad       (rd_bad),
    .rd_spare     (rd_spare),
    .result       (result),
    .result_valid (result_valid)
  );

  bbrt_ram #(.DEPTH(TABLE_DEPTH), .AW(IW), .W(bbrt_pkg::BLK_W)) u_bad_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.bad_block),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bad)
  );

  bbrt_ram #(.DEPTH(TABLE_DEPTH), .AW(IW), .W(bbrt_pkg::BLK_W)) u_spare_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.spare_block),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_spare)
  );

endmodule
